@@ hw/rtl/i8080_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package i8080_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_EXEC  = 2'd2;

  localparam logic [1:0] RUN_OK   = 2'd0;
  localparam logic [1:0] RUN_HALT = 2'd1;
  localparam logic [1:0] RUN_BAD  = 2'd2;

  // one queued request
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_byte;
  } req_t;

  // one result
  typedef struct packed {
    logic [7:0]  read_byte;
    logic [7:0]  acc;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [15:0] prog_count;
    logic [15:0] stack_top;
    logic [4:0]  flag_word;
    logic        irq_enabled;
    logic [1:0]  run_state;
  } res_t;

  function automatic logic even_par(input logic [7:0] v);
    even_par = ~^v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/i8080_partial_core_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// From input accept to result valid, a read or write passes the idle and done
// states and then the result register; an execute passes opcode fetch, up to two
// operand bytes, up to two data accesses on the single memory port, then the result register.
// The executor takes a new request only when idle; the two-entry queue holds the waiting ones.
// Reset: synchronous, clears registers, flags and the queue; memory is not
// cleared and holds garbage until written.
module i8080_partial_core_unit
  import i8080_pkg::*;
#(
  parameter int MEM_BYTES = 65536
)
(
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [31:0] s_tdata,  // func[1:0], address[17:2], write_byte[25:18]
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [103:0]      m_tdata   // read_byte, acc, bc, de, hl, pc, sp, flags,
                                      // irq_enabled, run_state (low to high)
);

  req_t in_req, q_req;
  logic q_valid, q_ready;
  res_t r;

  assign in_req = '{func: s_tdata[1:0], address: s_tdata[17:2],
                    write_byte: s_tdata[25:18]};

  i8080_req_fifo u_fifo (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
  );

  i8080_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
    .clk, .rst,
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(r)
  );

  assign m_tdata = {r.run_state, r.irq_enabled, r.flag_word, r.stack_top,
                    r.prog_count, r.pair_hl, r.pair_de, r.pair_bc, r.acc,
                    r.read_byte};

endmodule
`default_nettype wire

@@ hw/rtl/i8080_req_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module i8080_req_fifo
  import i8080_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  req_t in_req,
  output logic       out_valid,
  input  wire  logic out_ready,
  output req_t       out_req
);

  // two-entry queue between front and back
  req_t       slots [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_req   = slots[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_req;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/i8080_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none
module i8080_exec
  import i8080_pkg::*;
#(
  parameter int MEM_BYTES = 65536
)
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic req_valid,
  output logic       req_ready,
  input  wire  req_t req,
  output logic       res_valid,
  input  wire  logic res_ready,
  output res_t       res
);

  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_B1, S_B2, S_DATA, S_DATA2, S_DONE
  } state_t;

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rdata;
  logic       we;
  logic [15:0] maddr;
  logic [7:0]  wdata;

  state_t      state;
  logic [7:0]  a, b, c, d, e, h, l;
  logic [15:0] pc, sp;
  logic [4:0]  fl;
  logic        ie;
  logic [1:0]  run;
  logic [7:0]  op, b1, b2, rb;
  logic [1:0]  func;
  logic [7:0]  lo_tmp;
  logic        fin;

  // single-port memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[maddr[AW-1:0]] <= wdata;
    rdata <= mem[maddr[AW-1:0]];
  end

  logic [15:0] hl, de, bc, imm, ret_pc;
  assign hl  = {h, l};
  assign de  = {d, e};
  assign bc  = {b, c};
  assign imm = {b2, b1};
  // CALL return address, past the three instruction bytes
  assign ret_pc = pc + 16'd3;

  // decode of the current opcode: operand bytes needed, data access, its address and byte
  logic        need_data, data_wr, two_data, need_b1, need_b2;
  logic [15:0] daddr;
  logic [7:0]  dbyte;
  always_comb begin
    need_data = 1'b0; data_wr = 1'b0; two_data = 1'b0;
    daddr = hl; dbyte = a;
    need_b1 = 1'b0; need_b2 = 1'b0;
    case (op)
      8'h01, 8'h11, 8'h21, 8'h31, 8'hc3, 8'hc2: begin
        need_b1 = 1'b1; need_b2 = 1'b1;
      end
      8'h06, 8'h0e, 8'h26, 8'h3e, 8'hc6, 8'he6, 8'hfe, 8'hd3: need_b1 = 1'b1;
      8'h36: begin
        need_b1 = 1'b1; need_data = 1'b1; data_wr = 1'b1; dbyte = b1;
      end
      8'h32: begin
        need_b1 = 1'b1; need_b2 = 1'b1; need_data = 1'b1; data_wr = 1'b1;
      end
      8'h3a: begin
        need_b1 = 1'b1; need_b2 = 1'b1; need_data = 1'b1;
      end
      8'h1a: begin
        need_data = 1'b1; daddr = de;
      end
      8'h56, 8'h5e, 8'h66, 8'h7e, 8'h86: need_data = 1'b1;
      8'h77: begin
        need_data = 1'b1; data_wr = 1'b1;
      end
      8'hcd: begin
        need_b1 = 1'b1; need_b2 = 1'b1; need_data = 1'b1; data_wr = 1'b1;
        two_data = 1'b1;
      end
      8'hc9, 8'hc1, 8'hd1, 8'he1, 8'hf1: begin
        need_data = 1'b1; two_data = 1'b1;
      end
      8'hc5, 8'hd5, 8'he5, 8'hf5: begin
        need_data = 1'b1; data_wr = 1'b1; two_data = 1'b1;
      end
      default: ;
    endcase
  end

  // memory port mux
  always_comb begin
    we = 1'b0; maddr = pc; wdata = req.write_byte;
    unique case (state)
      S_IDLE: begin
        maddr = pc;
        if (req_valid && req_ready && req.func == FUNC_WRITE) begin
          we = 1'b1; maddr = req.address;
        end else if (req_valid && req.func == FUNC_READ) begin
          maddr = req.address;
        end
      end
      S_OP: maddr = pc + 16'd1;
      S_B1: maddr = pc + 16'd2;
      S_B2, S_DATA, S_DATA2, S_DONE: maddr = pc;
      default: ;
    endcase
    // data phase overrides
    if (state == S_DATA) begin
      maddr = daddr;
      wdata = dbyte;
      we    = data_wr;
      unique case (op)
        8'h32, 8'h3a: maddr = imm;
        8'hcd: begin maddr = sp - 16'd1; wdata = ret_pc[15:8]; end
        8'hc5: begin maddr = sp - 16'd1; wdata = b; end
        8'hd5: begin maddr = sp - 16'd1; wdata = d; end
        8'he5: begin maddr = sp - 16'd1; wdata = h; end
        8'hf5: begin maddr = sp - 16'd1; wdata = a; end
        8'hc9, 8'hc1, 8'hd1, 8'he1, 8'hf1: maddr = sp;
        default: ;
      endcase
    end else if (state == S_DATA2) begin
      we = data_wr;
      unique case (op)
        8'hcd: begin maddr = sp - 16'd2; wdata = ret_pc[7:0]; end
        8'hc5: begin maddr = sp - 16'd2; wdata = c; end
        8'hd5: begin maddr = sp - 16'd2; wdata = e; end
        8'he5: begin maddr = sp - 16'd2; wdata = l; end
        8'hf5: begin maddr = sp - 16'd2; wdata = {3'b000, fl}; end
        default: maddr = sp + 16'd1;
      endcase
    end
  end

  // a new request is taken only in idle, and waits there while a finished result cannot enter the full result register
  assign req_ready = (state == S_IDLE) && !(fin && res_valid && !res_ready);

  // execution of the ALU-style opcodes once operands are in hand
  logic [8:0] sum;
  logic [7:0] ov;
  logic [7:0] dv;
  always_comb begin
    case (op)
      8'h80: ov = b;
      8'h81: ov = c;
      8'h82: ov = d;
      8'h83: ov = e;
      8'h84: ov = h;
      8'h85: ov = l;
      8'h86: ov = rdata;
      8'h87: ov = a;
      default: ov = b1;
    endcase
    sum = {1'b0, a} + {1'b0, ov};
    dv  = a - b1;
  end

  logic [16:0] dsum;
  always_comb begin
    case (op)
      8'h09:   dsum = {1'b0, hl} + {1'b0, bc};
      8'h19:   dsum = {1'b0, hl} + {1'b0, de};
      default: dsum = {1'b0, hl} + {1'b0, hl};
    endcase
  end

  // S, Z, AC, P, C from a result byte with given AC and carry
  function automatic logic [4:0] flags_of(input logic [7:0] r, input logic ac,
                                          input logic cy);
    flags_of = {r[7], (r == 8'h00), ac, even_par(r), cy};
  endfunction

  function automatic logic [4:0] zsp(input logic [4:0] f, input logic [7:0] r);
    zsp = flags_of(r, f[2], f[0]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      a <= '0; b <= '0; c <= '0; d <= '0; e <= '0; h <= '0; l <= '0;
      pc <= '0; sp <= '0; fl <= '0; ie <= 1'b0; run <= RUN_OK;
      res_valid <= 1'b0;
      fin <= 1'b0;
    end else begin
      // result register: load the settled registers once the slot is free
      if (fin && (!res_valid || res_ready)) begin
        res <= '{read_byte: rb, acc: a, pair_bc: bc, pair_de: de, pair_hl: hl,
                 prog_count: pc, stack_top: sp, flag_word: fl,
                 irq_enabled: ie, run_state: run};
        res_valid <= 1'b1;
        fin <= 1'b0;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            func <= req.func;
            rb   <= 8'h00;
            if (req.func == FUNC_EXEC && run == RUN_OK) state <= S_OP;
            else state <= S_DONE;
          end
        end
        S_OP: begin
          op <= rdata;
          state <= S_B1;
        end
        S_B1: begin
          b1 <= rdata;
          if (need_b2) state <= S_B2;
          else if (need_data) state <= S_DATA;
          else state <= S_DONE;
        end
        S_B2: begin
          b2 <= rdata;
          if (need_data) state <= S_DATA;
          else state <= S_DONE;
        end
        S_DATA: state <= two_data ? S_DATA2 : S_DONE;
        S_DATA2: begin
          lo_tmp <= rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
          if (func == FUNC_READ) rb <= rdata;
          if (func == FUNC_EXEC && run == RUN_OK) begin
            pc <= pc + 16'd1;
            unique case (op)
              8'h00, 8'h08, 8'h10, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38,
              8'hcb, 8'hd9, 8'hdd, 8'hed, 8'hfd: ;
              8'h01: begin b <= b2; c <= b1; pc <= pc + 16'd3; end
              8'h11: begin d <= b2; e <= b1; pc <= pc + 16'd3; end
              8'h21: begin h <= b2; l <= b1; pc <= pc + 16'd3; end
              8'h31: begin sp <= {b2, b1}; pc <= pc + 16'd3; end
              8'h06: begin b <= b1; pc <= pc + 16'd2; end
              8'h0e: begin c <= b1; pc <= pc + 16'd2; end
              8'h26: begin h <= b1; pc <= pc + 16'd2; end
              8'h3e: begin a <= b1; pc <= pc + 16'd2; end
              8'h36: pc <= pc + 16'd2;
              8'h32: pc <= pc + 16'd3;
              8'h3a: begin a <= rdata; pc <= pc + 16'd3; end
              8'h1a: a <= rdata;
              8'h05: begin b <= b - 8'd1; fl <= zsp(fl, b - 8'd1); end
              8'h0d: begin c <= c - 8'd1; fl <= zsp(fl, c - 8'd1); end
              8'h0f: begin a <= {a[0], a[7:1]}; fl[0] <= a[0]; end
              8'h09, 8'h19, 8'h29: begin
                {h, l} <= dsum[15:0]; fl[0] <= dsum[16];
              end
              8'h13: {d, e} <= de + 16'd1;
              8'h23: {h, l} <= hl + 16'd1;
              8'h56: d <= rdata;
              8'h5e: e <= rdata;
              8'h66: h <= rdata;
              8'h6f: l <= a;
              8'h77: ;
              8'h7a: a <= d;
              8'h7b: a <= e;
              8'h7c: a <= h;
              8'h7e: a <= rdata;
              8'h76: run <= RUN_HALT;
              8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87: begin
                a <= sum[7:0]; fl <= flags_of(sum[7:0], fl[2], sum[8]);
              end
              8'hc6: begin
                a <= sum[7:0]; fl <= flags_of(sum[7:0], fl[2], sum[8]);
                pc <= pc + 16'd2;
              end
              8'ha7: begin a <= a; fl <= flags_of(a, 1'b0, 1'b0); end
              8'haf: begin a <= 8'h00; fl <= 5'b01010; end
              8'he6: begin
                a <= a & b1;
                fl <= flags_of(a & b1, 1'b0, 1'b0);
                pc <= pc + 16'd2;
              end
              8'hfe: begin
                fl <= flags_of(dv, fl[2], (b1 > a));
                pc <= pc + 16'd2;
              end
              8'hc2: pc <= fl[3] ? pc + 16'd3 : {b2, b1};
              8'hc3: pc <= {b2, b1};
              8'hcd: begin sp <= sp - 16'd2; pc <= {b2, b1}; end
              8'hc9: begin sp <= sp + 16'd2; pc <= {rdata, lo_tmp}; end
              8'hc1: begin sp <= sp + 16'd2; b <= rdata; c <= lo_tmp; end
              8'hd1: begin sp <= sp + 16'd2; d <= rdata; e <= lo_tmp; end
              8'he1: begin sp <= sp + 16'd2; h <= rdata; l <= lo_tmp; end
              8'hf1: begin sp <= sp + 16'd2; a <= rdata; fl <= lo_tmp[4:0]; end
              8'hc5, 8'hd5, 8'he5, 8'hf5: sp <= sp - 16'd2;
              8'hd3: pc <= pc + 16'd2;
              8'heb: begin d <= h; e <= l; h <= d; l <= e; end
              8'hfb: ie <= 1'b1;
              default: begin pc <= pc; run <= RUN_BAD; end
            endcase
          end
          fin <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
